FILE: hdl/egb_pkg.sv
package egb_pkg;

  localparam int MAX_ARMS_DEF    = 16;
  localparam int COUNT_WIDTH_DEF = 32;

  localparam int ARM_W      = 4;
  localparam int REWARD_W   = 17;
  localparam int DRAW_W     = 16;
  localparam int EPS_W      = 17;
  localparam int NA_W       = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 17;

  localparam int DIV_STEPS = REWARD_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  localparam logic [REWARD_W-1:0] Q_ONE   = 17'h10000;
  localparam logic [EPS_W-1:0]    EPS_RST = 17'd6554;
  localparam logic [NA_W-1:0]     NA_RST  = 5'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EPSILON  = 1'b0,
    CFG_NUM_ARMS = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic                has_feedback;
    logic [ARM_W-1:0]    arm;
    logic [REWARD_W-1:0] reward;
    logic [DRAW_W-1:0]   explore_draw;
    logic [ARM_W-1:0]    random_arm;
  } in_item_t;

  typedef struct packed {
    logic [ARM_W-1:0] chosen_arm;
    logic             explored;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_LOAD,
    ST_DIV,
    ST_WB,
    ST_DECIDE,
    ST_SCAN,
    ST_SCAN_END,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic take;
    logic rd_learn;
    logic div_load;
    logic div_step;
    logic wr_back;
    logic scan_clr;
    logic scan_rd;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic learn_en;
    logic div_last;
    logic explore;
    logic scan_last;
    logic out_free;
  } sts_t;

endpackage

FILE: hdl/epsilon_greedy_bandit_agent_core.sv
// Channel  Direction  Handshake            Payload
// in_      input      in_valid / in_stall  egb_pkg::in_item_t
// out_     output     out_valid/ out_stall egb_pkg::out_item_t
// cfg_     input      cfg_wr_en            cfg_index, cfg_wdata
//
// An item with feedback goes through one read, one load, the bit-serial divider
// and one write-back, then the argmax scan at one arm per cycle through the
// single read port of the stores. An explored item or one without feedback
// skips the parts it does not need.
// Reset is synchronous and marks all arm estimates and counts invalid at once.
// A stalled output holds the result, and the block takes one item at a time.
module epsilon_greedy_bandit_agent_core #(
  parameter int MAX_ARMS    = egb_pkg::MAX_ARMS_DEF,
  parameter int COUNT_WIDTH = egb_pkg::COUNT_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  egb_pkg::in_item_t              in_item,
  output logic                           out_valid,
  input  logic                           out_stall,
  output egb_pkg::out_item_t             out_item,
  input  logic                           cfg_wr_en,
  input  logic [egb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [egb_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import egb_pkg::*;

  cmd_t cmd;
  sts_t sts;

  egb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .sts      (sts),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  egb_dpath #(
    .MAX_ARMS    (MAX_ARMS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

FILE: hdl/egb_ctrl.sv
module egb_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  egb_pkg::sts_t sts,
  output egb_pkg::cmd_t cmd,
  output logic          in_stall
);
  import egb_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        state_nxt = sts.learn_en ? ST_LOAD : ST_DECIDE;
      end
      ST_LOAD: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (sts.div_last) begin
          state_nxt = ST_WB;
        end
      end
      ST_WB: begin
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        state_nxt = sts.explore ? ST_OUT : ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.scan_last) begin
          state_nxt = ST_SCAN_END;
        end
      end
      ST_SCAN_END: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.take = in_valid;
      end
      ST_START: begin
        cmd.rd_learn = 1'b1;
      end
      ST_LOAD: begin
        cmd.div_load = 1'b1;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      ST_WB: begin
        cmd.wr_back = 1'b1;
      end
      ST_DECIDE: begin
        cmd.scan_clr = 1'b1;
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
      end
      ST_SCAN_END: begin
        cmd = '0;
      end
      ST_OUT: begin
        cmd.out_load = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

FILE: hdl/egb_dpath.sv
module egb_dpath #(
  parameter int MAX_ARMS    = egb_pkg::MAX_ARMS_DEF,
  parameter int COUNT_WIDTH = egb_pkg::COUNT_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  egb_pkg::in_item_t                in_item,
  input  logic                             cfg_wr_en,
  input  logic [egb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [egb_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  egb_pkg::cmd_t                    cmd,
  output egb_pkg::sts_t                    sts,
  output logic                             out_valid,
  input  logic                             out_stall,
  output egb_pkg::out_item_t               out_item
);
  import egb_pkg::*;

  localparam int AW = (MAX_ARMS > 1) ? $clog2(MAX_ARMS) : 1;
  localparam int XW = AW + NA_W;
  localparam int CW = COUNT_WIDTH;
  localparam logic [CW-1:0] CMAX = {CW{1'b1}};

  in_item_t            item_r;
  logic [EPS_W-1:0]    eps_r;
  logic [NA_W-1:0]     na_r;

  logic [REWARD_W-1:0] val_mem [MAX_ARMS];
  logic [CW-1:0]       cnt_mem [MAX_ARMS];
  logic [MAX_ARMS-1:0] vld_r;

  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic [REWARD_W-1:0] val_q_r;
  logic [CW-1:0]       cnt_q_r;
  logic                rd_vld_r;
  logic [AW-1:0]       rd_idx_r;

  logic [XW-1:0]       arm_x;
  logic [AW-1:0]       arm_idx;
  logic [XW-1:0]       na_x;
  logic [XW-1:0]       last_x;
  logic [AW-1:0]       last_idx;
  logic [XW-1:0]       rarm_x;
  logic [XW-1:0]       clamp_x;
  logic [XW-1:0]       pick_x;
  logic                explore;

  logic [REWARD_W-1:0] q_cur;
  logic [CW-1:0]       c_cur;
  logic [REWARD_W-1:0] r_sat;
  logic                ge;
  logic [REWARD_W-1:0] diff;

  logic [REWARD_W-1:0] q_old_r;
  logic                ge_r;
  logic [CW-1:0]       cnt_new_r;
  logic [CW-1:0]       cnt_new_nxt;
  logic [REWARD_W-1:0] dvd_r;
  logic [REWARD_W-1:0] dvd_nxt;
  logic [CW-1:0]       rem_r;
  logic [CW-1:0]       rem_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic [DIV_CNT_W-1:0] div_cnt_nxt;
  logic [CW:0]         rem_sh;
  logic [CW:0]         rem_sub;
  logic                sub_ok;
  logic [REWARD_W-1:0] q_new;

  logic [AW-1:0]       scan_addr_r;
  logic [AW-1:0]       scan_addr_nxt;
  logic                scan_dv_r;
  logic                first_r;
  logic                first_nxt;
  logic [REWARD_W-1:0] best_r;
  logic [REWARD_W-1:0] best_nxt;
  logic [AW-1:0]       pick_r;
  logic [AW-1:0]       pick_nxt;
  logic [REWARD_W-1:0] scan_val;

  logic                out_vld_r;
  logic                out_vld_nxt;
  out_item_t           out_item_r;

  // Input item and configuration registers.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      item_r <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= EPS_RST;
      na_r  <= NA_RST;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        CFG_EPSILON:  eps_r <= cfg_wdata[EPS_W-1:0];
        CFG_NUM_ARMS: na_r  <= cfg_wdata[NA_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Arm range handling.
  assign arm_x    = XW'(item_r.arm);
  assign arm_idx  = arm_x[AW-1:0];
  assign na_x     = XW'(na_r);
  assign last_x   = (na_r == '0) ? '0 :
                    (na_x > XW'(MAX_ARMS)) ? XW'(MAX_ARMS - 1) : na_x - XW'(1);
  assign last_idx = last_x[AW-1:0];
  assign rarm_x   = XW'(item_r.random_arm);
  assign clamp_x  = (rarm_x > last_x) ? last_x : rarm_x;
  assign explore  = {1'b0, item_r.explore_draw} < eps_r;

  // Arm stores: one write port, one registered read port each.
  assign rd_en   = cmd.rd_learn | cmd.scan_rd;
  assign rd_addr = cmd.scan_rd ? scan_addr_r : arm_idx;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      val_q_r  <= val_mem[rd_addr];
      cnt_q_r  <= cnt_mem[rd_addr];
      rd_vld_r <= vld_r[rd_addr];
      rd_idx_r <= rd_addr;
    end
    if (cmd.wr_back) begin
      val_mem[arm_idx] <= q_new;
      cnt_mem[arm_idx] <= cnt_new_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (cmd.wr_back) begin
      vld_r[arm_idx] <= 1'b1;
    end
  end

  // Sample-average update with a restoring divider, one quotient bit per cycle.
  assign q_cur = rd_vld_r ? val_q_r : '0;
  assign c_cur = rd_vld_r ? cnt_q_r : '0;
  assign r_sat = (item_r.reward > Q_ONE) ? Q_ONE : item_r.reward;
  assign ge    = r_sat >= q_cur;
  assign diff  = ge ? (r_sat - q_cur) : (q_cur - r_sat);

  assign rem_sh  = {rem_r, dvd_r[REWARD_W-1]};
  assign rem_sub = rem_sh - {1'b0, cnt_new_r};
  assign sub_ok  = rem_sh >= {1'b0, cnt_new_r};
  assign q_new   = ge_r ? (q_old_r + dvd_r) : (q_old_r - dvd_r);

  always_comb begin
    cnt_new_nxt = cnt_new_r;
    dvd_nxt     = dvd_r;
    rem_nxt     = rem_r;
    div_cnt_nxt = div_cnt_r;
    if (cmd.div_load) begin
      cnt_new_nxt = (c_cur == CMAX) ? c_cur : c_cur + CW'(1);
      dvd_nxt     = diff;
      rem_nxt     = '0;
      div_cnt_nxt = '0;
    end else if (cmd.div_step) begin
      rem_nxt     = sub_ok ? rem_sub[CW-1:0] : rem_sh[CW-1:0];
      dvd_nxt     = {dvd_r[REWARD_W-2:0], sub_ok};
      div_cnt_nxt = div_cnt_r + DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      q_old_r <= q_cur;
      ge_r    <= ge;
    end
    cnt_new_r <= cnt_new_nxt;
    dvd_r     <= dvd_nxt;
    rem_r     <= rem_nxt;
    div_cnt_r <= div_cnt_nxt;
  end

  // Argmax scan over the arms in use, lowest index kept on a tie.
  assign scan_val = rd_vld_r ? val_q_r : '0;

  always_comb begin
    scan_addr_nxt = scan_addr_r;
    first_nxt     = first_r;
    best_nxt      = best_r;
    pick_nxt      = pick_r;
    if (cmd.scan_clr) begin
      scan_addr_nxt = '0;
      first_nxt     = 1'b1;
    end else if (cmd.scan_rd) begin
      scan_addr_nxt = scan_addr_r + AW'(1);
    end
    if (scan_dv_r && (first_r || (scan_val > best_r))) begin
      best_nxt  = scan_val;
      pick_nxt  = rd_idx_r;
      first_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    scan_addr_r <= scan_addr_nxt;
    first_r     <= first_nxt;
    best_r      <= best_nxt;
    pick_r      <= pick_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_dv_r <= 1'b0;
    end else begin
      scan_dv_r <= cmd.scan_rd;
    end
  end

  // Output register.
  assign pick_x      = explore ? clamp_x : XW'(pick_r);
  assign out_vld_nxt = cmd.out_load | (out_vld_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_item_r.chosen_arm <= pick_x[ARM_W-1:0];
      out_item_r.explored   <= explore;
    end
  end

  assign out_valid = out_vld_r;
  assign out_item  = out_item_r;

  assign sts.learn_en  = item_r.has_feedback & (arm_x < XW'(MAX_ARMS));
  assign sts.div_last  = div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1);
  assign sts.explore   = explore;
  assign sts.scan_last = scan_addr_r == last_idx;
  assign sts.out_free  = ~out_vld_r | ~out_stall;

endmodule

FILE: hdl/egb_checker.sv
module egb_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input egb_pkg::out_item_t out_item
);
  import egb_pkg::*;

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("item accepted while previous item still at work");

  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result appeared the cycle after an item was accepted");

  a_result_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !in_stall)
    else $error("result presented while block still busy");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

endmodule

bind epsilon_greedy_bandit_agent_core egb_checker u_egb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
